>>> rtl/slpis_pkg.sv
// ----------------------------------------------------------------------------
// Sorted list pool package
// Shared sizes, the nil link code, the command kind codes and the node store
// request and response types.
// ----------------------------------------------------------------------------
package slpis_pkg;

    // Number of nodes in the pool and width of a stored value.
    localparam int POOL_NODES    = 16;
    localparam int VALUE_BITS    = 16;

    // Fixed widths of the port fields.
    localparam int IN_VALUE_BITS = 16;
    localparam int POS_OUT_BITS  = 4;

    // A position addresses the pool; a link also holds the nil code.
    localparam int POS_BITS      = (POOL_NODES > 1) ? $clog2(POOL_NODES) : 1;
    localparam int PTR_BITS      = $clog2(POOL_NODES + 1);

    // The nil link is coded as the pool size.
    localparam logic [PTR_BITS-1:0] NIL_LINK = PTR_BITS'(POOL_NODES);

    // Command kind codes on the kind port.
    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_SEARCH = 1'b1;

    // One read of both arrays at the same position, and one write.
    typedef struct packed {
        logic                  rd_en;
        logic [POS_BITS-1:0]   rd_addr;
        logic                  val_wr_en;
        logic                  link_wr_en;
        logic [POS_BITS-1:0]   wr_addr;
        logic [VALUE_BITS-1:0] wr_value;
        logic [PTR_BITS-1:0]   wr_link;
    } mem_req_t;

    // Read data, registered; it appears in the cycle after the request.
    typedef struct packed {
        logic [VALUE_BITS-1:0] rd_value;
        logic [PTR_BITS-1:0]   rd_link;
    } mem_rsp_t;

endpackage

>>> rtl/slpis_node_store.sv
// ----------------------------------------------------------------------------
// Sorted list node store
// Value and link memories of the node pool, each with one synchronous read
// and one write port.
// ----------------------------------------------------------------------------
module slpis_node_store (
    input  logic                clk,
    input  logic                rst_n,
    input  slpis_pkg::mem_req_t req,
    output slpis_pkg::mem_rsp_t rsp
);

    logic [slpis_pkg::VALUE_BITS-1:0] value_mem [slpis_pkg::POOL_NODES];
    logic [slpis_pkg::PTR_BITS-1:0]   link_mem  [slpis_pkg::POOL_NODES];

    // A link entry that was never written reads as its reset value, the
    // next position up; the last entry thereby reads as nil.
    logic [slpis_pkg::POOL_NODES-1:0] link_valid_reg;
    logic                             rd_valid_reg;
    logic [slpis_pkg::POS_BITS-1:0]   rd_addr_reg;
    logic [slpis_pkg::VALUE_BITS-1:0] rd_value_reg;
    logic [slpis_pkg::PTR_BITS-1:0]   rd_link_reg;

    always_ff @(posedge clk)
    begin
        if (req.val_wr_en)
        begin
            value_mem[req.wr_addr] <= req.wr_value;
        end
        if (req.link_wr_en)
        begin
            link_mem[req.wr_addr] <= req.wr_link;
        end
        if (req.rd_en)
        begin
            rd_value_reg <= value_mem[req.rd_addr];
            rd_link_reg  <= link_mem[req.rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_valid_reg <= '0;
            rd_valid_reg   <= 1'b0;
            rd_addr_reg    <= '0;
        end
        else
        begin
            if (req.link_wr_en)
            begin
                link_valid_reg[req.wr_addr] <= 1'b1;
            end
            if (req.rd_en)
            begin
                rd_valid_reg <= link_valid_reg[req.rd_addr];
                rd_addr_reg  <= req.rd_addr;
            end
        end
    end

    assign rsp.rd_value = rd_value_reg;
    assign rsp.rd_link  = rd_valid_reg ? rd_link_reg
                        : slpis_pkg::PTR_BITS'(rd_addr_reg) + 1'b1;

endmodule

>>> rtl/sorted_list_pool_insert_search_core.sv
// ----------------------------------------------------------------------------
// Sorted list pool insert and search core
// Keeps an ascending singly linked list in a fixed node pool, with a free
// list threaded through the unused nodes, and serves inserts and searches.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake                 Payload
// command   in         start high, busy low      kind, value
// result    out        done strobe, one cycle    found, has_pred, pred_position,
//                                                rejected_full, stored_position,
//                                                list_empty, pool_exhausted
//
// An item walks the list one node per cycle, since the link read from the
// node store is the address of the next read. A search or a refused insert
// gives its result from the decide state; an insert then writes the new node
// and, after a predecessor, relinks the predecessor before its result. A walk
// stops at the end of the list or after POOL_NODES nodes.
// The reset takes effect at once: link entries carry valid bits, so no
// clearing pass is needed. busy stays high until the result is shown, and
// the result cannot be stalled; it is shown for one cycle only.
// ----------------------------------------------------------------------------
module sorted_list_pool_insert_search_core (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic                                   kind,
    input  logic signed [slpis_pkg::IN_VALUE_BITS-1:0] value,
    output logic                                   done,
    output logic                                   found,
    output logic                                   has_pred,
    output logic [slpis_pkg::POS_OUT_BITS-1:0]     pred_position,
    output logic                                   rejected_full,
    output logic [slpis_pkg::POS_OUT_BITS-1:0]     stored_position,
    output logic                                   list_empty,
    output logic                                   pool_exhausted
);

    localparam int STEP_BITS = $clog2(slpis_pkg::POOL_NODES + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WALK,
        ST_DECIDE,
        ST_LINK_SLOT,
        ST_LINK_PRED
    } state_t;

    // The command value cut or sign extended to the stored width.
    function automatic logic [slpis_pkg::VALUE_BITS-1:0] fit_value(
        input logic [slpis_pkg::IN_VALUE_BITS-1:0] raw
    );
        logic [slpis_pkg::VALUE_BITS-1:0] r;
        r = '0;
        for (int i = 0; i < slpis_pkg::VALUE_BITS; i++)
        begin
            r[i] = raw[(i < slpis_pkg::IN_VALUE_BITS) ? i : slpis_pkg::IN_VALUE_BITS - 1];
        end
        return r;
    endfunction

    // A pool position shown on a 4-bit field.
    function automatic logic [slpis_pkg::POS_OUT_BITS-1:0] out_pos(
        input logic [slpis_pkg::POS_BITS-1:0] p
    );
        logic [slpis_pkg::POS_OUT_BITS-1:0] r;
        r = '0;
        for (int i = 0; i < slpis_pkg::POS_OUT_BITS; i++)
        begin
            r[i] = (i < slpis_pkg::POS_BITS) ? p[(i < slpis_pkg::POS_BITS) ? i : 0] : 1'b0;
        end
        return r;
    endfunction

    slpis_pkg::mem_req_t mem_req;
    slpis_pkg::mem_rsp_t mem_rsp;

    state_t                                state_reg, state_next;
    logic                                  kind_reg, kind_next;
    logic signed [slpis_pkg::VALUE_BITS-1:0] item_reg, item_next;
    logic [slpis_pkg::PTR_BITS-1:0]        cur_reg, cur_next;
    logic [slpis_pkg::POS_BITS-1:0]        pred_reg, pred_next;
    logic                                  has_pred_reg, has_pred_next;
    logic                                  found_reg, found_next;
    logic [STEP_BITS-1:0]                  steps_reg, steps_next;
    logic [slpis_pkg::PTR_BITS-1:0]        list_head_reg, list_head_next;
    logic [slpis_pkg::PTR_BITS-1:0]        free_head_reg, free_head_next;
    logic [slpis_pkg::POS_BITS-1:0]        slot_reg, slot_next;

    logic                                  done_reg, done_next;
    logic                                  found_out_reg, found_out_next;
    logic                                  has_pred_out_reg, has_pred_out_next;
    logic [slpis_pkg::POS_OUT_BITS-1:0]    pred_pos_reg, pred_pos_next;
    logic                                  rejected_reg, rejected_next;
    logic [slpis_pkg::POS_OUT_BITS-1:0]    stored_pos_reg, stored_pos_next;
    logic                                  list_empty_reg, list_empty_next;
    logic                                  pool_exh_reg, pool_exh_next;

    logic signed [slpis_pkg::VALUE_BITS-1:0] node_val;
    logic [slpis_pkg::PTR_BITS-1:0]        node_link;
    logic [STEP_BITS-1:0]                  steps_inc;

    assign node_val  = mem_rsp.rd_value;
    assign node_link = mem_rsp.rd_link;
    assign steps_inc = steps_reg + 1'b1;

    always_comb
    begin
        state_next        = state_reg;
        kind_next         = kind_reg;
        item_next         = item_reg;
        cur_next          = cur_reg;
        pred_next         = pred_reg;
        has_pred_next     = has_pred_reg;
        found_next        = found_reg;
        steps_next        = steps_reg;
        list_head_next    = list_head_reg;
        free_head_next    = free_head_reg;
        slot_next         = slot_reg;
        done_next         = 1'b0;
        found_out_next    = found_out_reg;
        has_pred_out_next = has_pred_out_reg;
        pred_pos_next     = pred_pos_reg;
        rejected_next     = rejected_reg;
        stored_pos_next   = stored_pos_reg;
        list_empty_next   = list_empty_reg;
        pool_exh_next     = pool_exh_reg;

        mem_req            = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    kind_next     = kind;
                    item_next     = fit_value(value);
                    cur_next      = list_head_reg;
                    has_pred_next = 1'b0;
                    pred_next     = '0;
                    found_next    = 1'b0;
                    steps_next    = '0;
                    if (list_head_reg < slpis_pkg::NIL_LINK)
                    begin
                        mem_req.rd_en   = 1'b1;
                        mem_req.rd_addr = list_head_reg[slpis_pkg::POS_BITS-1:0];
                        state_next      = ST_WALK;
                    end
                    else
                    begin
                        state_next = ST_DECIDE;
                    end
                end
            end

            ST_WALK:
            begin
                // The node at cur_reg has just been read.
                if (node_val >= item_reg)
                begin
                    found_next = (node_val == item_reg);
                    state_next = ST_DECIDE;
                end
                else
                begin
                    pred_next     = cur_reg[slpis_pkg::POS_BITS-1:0];
                    has_pred_next = 1'b1;
                    cur_next      = node_link;
                    steps_next    = steps_inc;
                    if (node_link < slpis_pkg::NIL_LINK
                        && steps_inc < STEP_BITS'(slpis_pkg::POOL_NODES))
                    begin
                        mem_req.rd_en   = 1'b1;
                        mem_req.rd_addr = node_link[slpis_pkg::POS_BITS-1:0];
                    end
                    else
                    begin
                        state_next = ST_DECIDE;
                    end
                end
            end

            ST_DECIDE:
            begin
                found_out_next    = found_reg;
                has_pred_out_next = has_pred_reg;
                pred_pos_next     = has_pred_reg ? out_pos(pred_reg) : '0;
                stored_pos_next   = '0;
                list_empty_next   = (list_head_reg >= slpis_pkg::NIL_LINK);
                pool_exh_next     = (free_head_reg >= slpis_pkg::NIL_LINK);
                rejected_next     = 1'b0;
                if (kind_reg == slpis_pkg::KIND_INSERT
                    && free_head_reg < slpis_pkg::NIL_LINK)
                begin
                    // Fetch the link of the free head to find the next free node.
                    slot_next       = free_head_reg[slpis_pkg::POS_BITS-1:0];
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = free_head_reg[slpis_pkg::POS_BITS-1:0];
                    state_next      = ST_LINK_SLOT;
                end
                else
                begin
                    rejected_next = (kind_reg == slpis_pkg::KIND_INSERT);
                    done_next     = 1'b1;
                    state_next    = ST_IDLE;
                end
            end

            ST_LINK_SLOT:
            begin
                free_head_next     = node_link;
                mem_req.val_wr_en  = 1'b1;
                mem_req.link_wr_en = 1'b1;
                mem_req.wr_addr    = slot_reg;
                mem_req.wr_value   = item_reg;
                mem_req.wr_link    = has_pred_reg ? cur_reg : list_head_reg;
                stored_pos_next    = out_pos(slot_reg);
                pool_exh_next      = (node_link >= slpis_pkg::NIL_LINK);
                if (has_pred_reg)
                begin
                    state_next = ST_LINK_PRED;
                end
                else
                begin
                    list_head_next  = slpis_pkg::PTR_BITS'(slot_reg);
                    list_empty_next = 1'b0;
                    done_next       = 1'b1;
                    state_next      = ST_IDLE;
                end
            end

            ST_LINK_PRED:
            begin
                mem_req.link_wr_en = 1'b1;
                mem_req.wr_addr    = pred_reg;
                mem_req.wr_link    = slpis_pkg::PTR_BITS'(slot_reg);
                list_empty_next    = 1'b0;
                done_next          = 1'b1;
                state_next         = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            kind_reg         <= 1'b0;
            item_reg         <= '0;
            cur_reg          <= slpis_pkg::NIL_LINK;
            pred_reg         <= '0;
            has_pred_reg     <= 1'b0;
            found_reg        <= 1'b0;
            steps_reg        <= '0;
            list_head_reg    <= slpis_pkg::NIL_LINK;
            free_head_reg    <= '0;
            slot_reg         <= '0;
            done_reg         <= 1'b0;
            found_out_reg    <= 1'b0;
            has_pred_out_reg <= 1'b0;
            pred_pos_reg     <= '0;
            rejected_reg     <= 1'b0;
            stored_pos_reg   <= '0;
            list_empty_reg   <= 1'b1;
            pool_exh_reg     <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            kind_reg         <= kind_next;
            item_reg         <= item_next;
            cur_reg          <= cur_next;
            pred_reg         <= pred_next;
            has_pred_reg     <= has_pred_next;
            found_reg        <= found_next;
            steps_reg        <= steps_next;
            list_head_reg    <= list_head_next;
            free_head_reg    <= free_head_next;
            slot_reg         <= slot_next;
            done_reg         <= done_next;
            found_out_reg    <= found_out_next;
            has_pred_out_reg <= has_pred_out_next;
            pred_pos_reg     <= pred_pos_next;
            rejected_reg     <= rejected_next;
            stored_pos_reg   <= stored_pos_next;
            list_empty_reg   <= list_empty_next;
            pool_exh_reg     <= pool_exh_next;
        end
    end

    slpis_node_store u_node_store (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mem_req),
        .rsp   (mem_rsp)
    );

    assign busy            = (state_reg != ST_IDLE);
    assign done            = done_reg;
    assign found           = found_out_reg;
    assign has_pred        = has_pred_out_reg;
    assign pred_position   = pred_pos_reg;
    assign rejected_full   = rejected_reg;
    assign stored_position = stored_pos_reg;
    assign list_empty      = list_empty_reg;
    assign pool_exhausted  = pool_exh_reg;

`ifndef SYNTHESIS
    // Every item passes at least the idle and decide states, so results never come back to back.
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held for two cycles");

    // The core leaves its busy phase only by delivering a result.
    a_busy_ends_in_result: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("busy dropped without a result");

    // A command transfer always starts a busy phase.
    a_start_sets_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("command transfer did not start work");

    // A refused insert happens only with an exhausted pool and stores nothing.
    a_reject_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        (done && rejected_full) |-> (pool_exhausted && stored_position == '0))
        else $error("refused insert with free nodes or a stored position");

    // Without a predecessor the position field reads as zero.
    a_pred_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !has_pred) |-> (pred_position == '0))
        else $error("predecessor position set without a predecessor");
`endif

endmodule

>>> tb/tb_sorted_list_pool_insert_search_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the sorted list pool insert and search core
// Drives inserts and searches through the start/busy command port, keeps a
// shadow copy of the list and the free chain to predict every result, and
// checks each done strobe field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_sorted_list_pool_insert_search_core;
    import slpis_pkg::*;

    localparam int CLK_PERIOD_NS = 10;
    localparam int RESET_CYCLES  = 9;
    localparam int RANDOM_ITEMS  = 700;
    // Drain time covering the longest walk plus linking, with a margin.
    localparam int DRAIN_CYCLES  = POOL_NODES + 8;
    // Slowest run is roughly 720 items with their gaps, with a wide margin.
    localparam int CYCLE_LIMIT   = 400000;

    localparam logic signed [IN_VALUE_BITS-1:0] VALUE_MIN = 16'sh8000;
    localparam logic signed [IN_VALUE_BITS-1:0] VALUE_MAX = 16'sh7FFF;

    typedef enum logic
    {
        CMD_INSERT = KIND_INSERT,
        CMD_SEARCH = KIND_SEARCH
    } command_kind_t;

    // One result item as the block presents it on its output ports.
    typedef struct packed
    {
        logic                    found;
        logic                    has_pred;
        logic [POS_OUT_BITS-1:0] pred_position;
        logic                    rejected_full;
        logic [POS_OUT_BITS-1:0] stored_position;
        logic                    list_empty;
        logic                    pool_exhausted;
    } list_result_t;

    logic                           clk;
    logic                           rst_n;
    logic                           start;
    logic                           busy;
    logic                           kind;
    logic signed [IN_VALUE_BITS-1:0] value;
    logic                           done;
    logic                           found;
    logic                           has_pred;
    logic [POS_OUT_BITS-1:0]        pred_position;
    logic                           rejected_full;
    logic [POS_OUT_BITS-1:0]        stored_position;
    logic                           list_empty;
    logic                           pool_exhausted;

    // Shadow copy of the node pool, the sorted list head and the free chain.
    logic signed [VALUE_BITS-1:0]   shadow_value [POOL_NODES];
    logic [PTR_BITS-1:0]            shadow_link  [POOL_NODES];
    logic [PTR_BITS-1:0]            shadow_head;
    logic [PTR_BITS-1:0]            shadow_free;

    // Results still owed by the block, oldest first.
    list_result_t                   pending_results [$];
    // Every value that made it into the list, used to aim searches at hits.
    logic signed [IN_VALUE_BITS-1:0] listed_values [$];

    int                             error_count;
    int                             cycle_count;

    sorted_list_pool_insert_search_core dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .kind            (kind),
        .value           (value),
        .done            (done),
        .found           (found),
        .has_pred        (has_pred),
        .pred_position   (pred_position),
        .rejected_full   (rejected_full),
        .stored_position (stored_position),
        .list_empty      (list_empty),
        .pool_exhausted  (pool_exhausted)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #(CLK_PERIOD_NS / 2) clk = ~clk;
        end
    end

    // Guard against a hang: a stuck busy or a missing done ends the run here.
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count >= CYCLE_LIMIT)
            begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // Walks the shadow list exactly as the block should, applies an insert to
    // the shadow state and returns the result that the item must produce.
    // The walk stops at the first node not smaller than the item, so a new
    // value goes in front of any equal values already in the list.
    function automatic list_result_t predict_list_op(command_kind_t op,
                                                     logic signed [IN_VALUE_BITS-1:0] raw);
        list_result_t                 res;
        logic signed [VALUE_BITS-1:0] item;
        logic [PTR_BITS-1:0]          cur;
        logic [PTR_BITS-1:0]          pred;
        logic [PTR_BITS-1:0]          slot;
        int                           steps;
        res   = '0;
        item  = VALUE_BITS'(raw);
        cur   = shadow_head;
        pred  = NIL_LINK;
        steps = 0;
        while (cur < POOL_NODES && steps < POOL_NODES)
        begin
            if (shadow_value[cur[POS_BITS-1:0]] >= item)
            begin
                res.found = (shadow_value[cur[POS_BITS-1:0]] == item);
                break;
            end
            pred = cur;
            cur  = shadow_link[cur[POS_BITS-1:0]];
            steps++;
        end
        if (op == CMD_INSERT)
        begin
            if (shadow_free >= POOL_NODES)
            begin
                // A full pool refuses the insert and leaves all state alone.
                res.rejected_full = 1'b1;
            end
            else
            begin
                slot        = shadow_free;
                shadow_free = shadow_link[slot[POS_BITS-1:0]];
                shadow_value[slot[POS_BITS-1:0]] = item;
                if (pred >= POOL_NODES)
                begin
                    shadow_link[slot[POS_BITS-1:0]] = shadow_head;
                    shadow_head = slot;
                end
                else
                begin
                    shadow_link[slot[POS_BITS-1:0]] = shadow_link[pred[POS_BITS-1:0]];
                    shadow_link[pred[POS_BITS-1:0]] = slot;
                end
                res.stored_position = POS_OUT_BITS'(slot);
                listed_values.push_back(raw);
            end
        end
        res.has_pred       = (pred < POOL_NODES);
        res.pred_position  = res.has_pred ? POS_OUT_BITS'(pred) : '0;
        res.list_empty     = (shadow_head >= POOL_NODES);
        res.pool_exhausted = (shadow_free >= POOL_NODES);
        return res;
    endfunction

    function automatic void compare_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endfunction

    // Every done strobe is a transfer that cannot be held off, so each one is
    // taken at the rising edge that closes its cycle and matched against the
    // oldest outstanding prediction.
    always @(posedge clk)
    begin : result_check
        list_result_t seen;
        list_result_t want;
        if (rst_n && done)
        begin
            seen = {found, has_pred, pred_position, rejected_full,
                    stored_position, list_empty, pool_exhausted};
            if (pending_results.size() == 0)
            begin
                $error("unexpected result: no prediction outstanding");
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                compare_field("found", want.found, seen.found);
                compare_field("has_pred", want.has_pred, seen.has_pred);
                compare_field("pred_position", want.pred_position, seen.pred_position);
                compare_field("rejected_full", want.rejected_full, seen.rejected_full);
                compare_field("stored_position", want.stored_position,
                              seen.stored_position);
                compare_field("list_empty", want.list_empty, seen.list_empty);
                compare_field("pool_exhausted", want.pool_exhausted, seen.pool_exhausted);
            end
        end
    end

    // Mostly back-to-back or short gaps, now and then a long one.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Values are aimed at the list contents so that searches hit at every
    // depth, land just beside stored values, or sit at the extremes; the rest
    // lie near zero or are spread over the whole field so that every bit toggles.
    function automatic logic signed [IN_VALUE_BITS-1:0] pick_value();
        int                              roll;
        int                              count;
        logic signed [IN_VALUE_BITS-1:0] base;
        roll  = $urandom_range(0, 9);
        count = listed_values.size();
        if (count > 0 && roll < 5)
        begin
            base = listed_values[$urandom_range(0, count - 1)];
            if (roll == 4)
                return $urandom_range(0, 1) ? base + 16'sd1 : base - 16'sd1;
            return base;
        end
        if (roll == 5)
            return $urandom_range(0, 1) ? VALUE_MAX : VALUE_MIN;
        if (roll == 6)
            return IN_VALUE_BITS'($urandom_range(0, 16) - 8);
        return IN_VALUE_BITS'($urandom);
    endfunction

    // Holds start low for the given number of cycles. kind and value carry
    // noise meanwhile, which the block must ignore.
    task automatic idle_for(int cycles);
        if (cycles > 0)
        begin
            @(negedge clk);
            start <= 1'b0;
            kind  <= 1'($urandom_range(0, 1));
            value <= IN_VALUE_BITS'($urandom);
            repeat (cycles - 1)
            begin
                @(negedge clk);
                kind  <= 1'($urandom_range(0, 1));
                value <= IN_VALUE_BITS'($urandom);
            end
        end
    endtask

    // Presents one command and waits for its transfer, which happens at the
    // first rising edge with busy low. start is left high afterwards so that a
    // following command can go out back to back; idle_for lowers it.
    task automatic send_command(command_kind_t op, logic signed [IN_VALUE_BITS-1:0] v,
                                int gap_after);
        @(negedge clk);
        start <= 1'b1;
        kind  <= op;
        value <= v;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_results.push_back(predict_list_op(op, v));
        idle_for(gap_after);
    endtask

    task automatic wait_all_results();
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // The sender stops and lets every outstanding result come back first.
    task automatic pause_until_drained();
        @(negedge clk);
        start <= 1'b0;
        wait_all_results();
    endtask

    // Searches on the empty list: no predecessor, nothing found.
    task automatic test_empty_list();
        send_command(CMD_SEARCH, 16'sd0, pick_gap());
        send_command(CMD_SEARCH, VALUE_MIN, pick_gap());
        send_command(CMD_SEARCH, VALUE_MAX, pick_gap());
    endtask

    // Inserts at the head of an empty list, in front of the head, at the
    // tail and in the middle.
    task automatic test_sorted_inserts();
        send_command(CMD_INSERT, 16'sd0, pick_gap());
        send_command(CMD_INSERT, VALUE_MIN, pick_gap());
        send_command(CMD_INSERT, VALUE_MAX, pick_gap());
        send_command(CMD_INSERT, 16'sd100, pick_gap());
        pause_until_drained();
    endtask

    // Equal values go in front of their equals; searches hit both extremes,
    // a stored middle value and the gaps beside it.
    task automatic test_equal_values();
        send_command(CMD_INSERT, 16'sd0, pick_gap());
        send_command(CMD_INSERT, VALUE_MAX, pick_gap());
        send_command(CMD_INSERT, VALUE_MIN, pick_gap());
        send_command(CMD_SEARCH, 16'sd0, pick_gap());
        send_command(CMD_SEARCH, VALUE_MAX, pick_gap());
        send_command(CMD_SEARCH, VALUE_MIN, pick_gap());
        send_command(CMD_SEARCH, 16'sd1, pick_gap());
        send_command(CMD_SEARCH, -16'sd1, pick_gap());
        send_command(CMD_SEARCH, 16'sh7FFE, pick_gap());
    endtask

    // A quarter inserts, which fill the pool early on, and then searches and
    // refused inserts over the full list. Every third stretch of sixty items
    // runs with no gaps at all, and now and then the sender drains.
    task automatic test_random_mix();
        command_kind_t op;
        int            gap;
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            op  = ($urandom_range(0, 3) == 0) ? CMD_INSERT : CMD_SEARCH;
            gap = ((i / 60) % 3 == 2) ? 0 : pick_gap();
            send_command(op, pick_value(), gap);
            if (i % 150 == 75)
                pause_until_drained();
        end
    endtask

    // Makes sure the pool is full, then checks that inserts are refused
    // without touching the list and that searches still see every node.
    task automatic test_full_pool();
        while (shadow_free < POOL_NODES)
            send_command(CMD_INSERT, pick_value(), pick_gap());
        send_command(CMD_INSERT, VALUE_MIN, pick_gap());
        send_command(CMD_INSERT, VALUE_MAX, pick_gap());
        send_command(CMD_INSERT, 16'sd5, pick_gap());
        send_command(CMD_SEARCH, VALUE_MAX, pick_gap());
        send_command(CMD_SEARCH, VALUE_MIN, pick_gap());
    endtask

    initial
    begin
        error_count = 0;
        rst_n       = 1'b0;
        start       = 1'b0;
        kind        = CMD_INSERT;
        value       = '0;
        // Reset picture of the shadow pool: every node chained into the free
        // list in order, the last one nil, and an empty sorted list.
        for (int i = 0; i < POOL_NODES; i++)
        begin
            shadow_value[i] = '0;
            shadow_link[i]  = PTR_BITS'(i + 1);
        end
        shadow_link[POOL_NODES - 1] = NIL_LINK;
        shadow_head = NIL_LINK;
        shadow_free = '0;

        repeat (RESET_CYCLES)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_empty_list();
        test_sorted_inserts();
        test_equal_values();
        test_random_mix();
        test_full_pool();

        @(negedge clk);
        start <= 1'b0;
        wait_all_results();
        // Any stray strobe after the last one is caught by the result check.
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        if (error_count == 0 && pending_results.size() == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
